// ===== hw/rtl/bsm_pkg.sv =====
// Package for the bounded substring matcher.
// Holds the sizing constants, register indexes and transaction types.
// No dependencies.
package bsm_pkg;

    localparam int PATTERN_MAX   = 8;
    localparam int POSITION_BITS = 16;
    localparam int LEN_W         = 4;
    localparam int LIMIT_W       = 16;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_LIMIT   = 2'd2;

    localparam logic [7:0] NUL_BYTE = 8'h00;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic                     match_found;
        logic [POSITION_BITS-1:0] match_start;
        logic                     search_done;
    } out_t;

    typedef struct packed {
        logic [8*PATTERN_MAX-1:0] pattern_bytes;
        logic [LEN_W-1:0]         pattern_length;
        logic [LIMIT_W-1:0]       search_limit;
    } cfg_t;

endpackage

// ===== hw/rtl/bsm_cfg_regs.sv =====
// Configuration registers of the bounded substring matcher.
// Depends on bsm_pkg.
module bsm_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [bsm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bsm_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output bsm_pkg::cfg_t                    cfg
);
    import bsm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PATTERN_BYTES: begin
                    cfg_next.pattern_bytes = cfg_wr_data[8*PATTERN_MAX-1:0];
                end
                CFG_PATTERN_LENGTH: begin
                    cfg_next.pattern_length = cfg_wr_data[LEN_W-1:0];
                end
                CFG_SEARCH_LIMIT: begin
                    cfg_next.search_limit = cfg_wr_data[LIMIT_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/bsm_match_core.sv =====
// Search state and single-pass match logic of the bounded substring matcher.
// Depends on bsm_pkg.
module bsm_match_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  bsm_pkg::in_t  item,
    input  bsm_pkg::cfg_t cfg,
    output bsm_pkg::out_t result
);
    import bsm_pkg::*;

    logic [PATTERN_MAX-1:0][7:0]  window_reg;
    logic [PATTERN_MAX-1:0][7:0]  window_next;
    logic [POSITION_BITS-1:0]     pos_reg;
    logic [POSITION_BITS-1:0]     pos_next;
    logic                         found_reg;
    logic                         found_next;
    logic [POSITION_BITS-1:0]     offset_reg;
    logic [POSITION_BITS-1:0]     offset_next;

    logic [PATTERN_MAX-1:0][7:0]  pat;
    logic [PATTERN_MAX-1:0][7:0]  win_shift;
    logic [LEN_W-1:0]             len_clip;
    logic [LEN_W-1:0]             eff_len;
    logic [POSITION_BITS-1:0]     eff_len_ext;
    logic [PATTERN_MAX-1:0]       hit_len;
    logic                         hit_sel;
    logic [POSITION_BITS-1:0]     count;
    logic                         is_nul;
    logic                         found_pre;
    logic                         new_match;
    logic                         found_out;
    logic [POSITION_BITS-1:0]     offset_out;
    logic                         done;

    assign pat = cfg.pattern_bytes;

    always_comb begin
        if (cfg.pattern_length > LEN_W'(PATTERN_MAX)) begin
            len_clip = LEN_W'(PATTERN_MAX);
        end else begin
            len_clip = cfg.pattern_length;
        end
        eff_len = len_clip;
        for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
            if ((LEN_W'(k) < len_clip) && (pat[k] == NUL_BYTE)) begin
                eff_len = LEN_W'(k);
            end
        end
    end

    assign eff_len_ext = POSITION_BITS'(eff_len);

    always_comb begin
        win_shift[0] = item.text_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            win_shift[k] = window_reg[k-1];
        end
    end

    always_comb begin
        for (int l = 1; l <= PATTERN_MAX; l++) begin
            hit_len[l-1] = 1'b1;
            for (int k = 0; k < l; k++) begin
                if (win_shift[l-1-k] != pat[k]) begin
                    hit_len[l-1] = 1'b0;
                end
            end
        end
        hit_sel = 1'b0;
        for (int l = 1; l <= PATTERN_MAX; l++) begin
            if (eff_len == LEN_W'(l)) begin
                hit_sel = hit_len[l-1];
            end
        end
    end

    assign count = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 1'b1;
    assign is_nul = (item.text_byte == NUL_BYTE);
    assign found_pre = found_reg || (eff_len == '0);

    assign new_match = !is_nul && !found_pre && hit_sel
                       && (count >= eff_len_ext)
                       && (count <= POSITION_BITS'(cfg.search_limit));

    assign found_out  = found_pre || new_match;
    assign offset_out = new_match ? (count - eff_len_ext)
                                  : (found_reg ? offset_reg : '0);

    assign done = is_nul || item.last_byte
                  || (count >= POSITION_BITS'(cfg.search_limit))
                  || (count == POS_MAX);

    always_comb begin
        result.match_found = found_out;
        result.match_start = found_out ? offset_out : '0;
        result.search_done = done;
    end

    always_comb begin
        window_next = window_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        offset_next = offset_reg;
        if (fire) begin
            if (done) begin
                window_next = '0;
                pos_next    = '0;
                found_next  = 1'b0;
                offset_next = '0;
            end else begin
                window_next = win_shift;
                pos_next    = count;
                found_next  = found_out;
                offset_next = offset_out;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            pos_reg    <= '0;
            found_reg  <= 1'b0;
            offset_reg <= '0;
        end else begin
            window_reg <= window_next;
            pos_reg    <= pos_next;
            found_reg  <= found_next;
            offset_reg <= offset_next;
        end
    end

endmodule

// ===== hw/rtl/bounded_substring_matcher.sv =====
// Bounded substring matcher, top level.
// Depends on bsm_pkg, bsm_cfg_regs and bsm_match_core.
//
// Usage:
//   s_valid/s_ready/s_data carry one haystack byte per transaction with a
//   last_byte flag. m_valid/m_ready/m_data return one result per input
//   transaction: match_found, match_start and search_done.
//   cfg_wr_en/cfg_index/cfg_wr_data write pattern_bytes (0), pattern_length
//   (1) and search_limit (2); write only while no transaction is in flight.
//   A search ends on a zero byte, the last_byte flag or the limit; the
//   result carrying search_done closes it and the next byte starts afresh.
// Timing:
//   The byte is held in the input register, matched against the 8-byte
//   window in one pass and captured in the result register. Throughput is
//   one transaction per cycle while m_ready stays high, set by the single
//   window compare between those two registers.
// Reset:
//   aresetn low clears the configuration, the valid flags, the window, the
//   position and the found flag; m_valid is low and s_ready high after it.
// Stall:
//   With m_ready low the result is held; a byte is taken into the input
//   register if it is empty, then s_ready drops until the result is accepted.
module bounded_substring_matcher (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  bsm_pkg::in_t                     s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output bsm_pkg::out_t                    m_data,
    input  logic                             cfg_wr_en,
    input  logic [bsm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bsm_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import bsm_pkg::*;

    cfg_t cfg;
    in_t  in_data_reg;
    logic in_valid_reg;
    logic in_valid_next;
    out_t out_data_reg;
    logic out_valid_reg;
    logic out_valid_next;
    out_t result;
    logic advance;
    logic fire;

    bsm_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    bsm_match_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== hw/rtl/bsm_checker.sv =====
// Port-level checks for the bounded substring matcher.
// Depends on bsm_pkg; bound to bounded_substring_matcher.
module bsm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input bsm_pkg::in_t                     s_data,
    input logic                             m_valid,
    input logic                             m_ready,
    input bsm_pkg::out_t                    m_data
);
    import bsm_pkg::*;

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input transaction dropped or changed while stalled");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.match_found |-> m_data.match_start == '0)
        else $error("match_start set without a match");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while the result side can advance");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind bounded_substring_matcher bsm_checker u_bsm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);
